>>> rtl/tdf_pkg.sv
// Shared types and constants of the trial division factorizer.
package tdf_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int VALUE_IN_W          = 32;
    localparam int PRIME_W             = 32;
    localparam int EXP_W               = 5;
    localparam int MAX_RESULTS         = 9;

    typedef struct packed {
        logic [VALUE_IN_W-1:0] value;
    } tdf_in_t;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exponent;
        logic               last;
    } tdf_out_t;

endpackage

>>> rtl/tdf_stream_if.sv
// Valid/ready stream interface that carries one payload per beat.
interface tdf_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> rtl/tdf_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tdf_divider #(
    parameter int W = tdf_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W+1:0]  diff;

    // The dividend shifts out at the top of quo_reg while quotient bits shift in below.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[W+1])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/tdf_result_reg.sv
// One-entry output register that holds a finished factor until it is taken.
module tdf_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tdf_pkg::tdf_out_t push_data,
    output logic              space,
    tdf_stream_if.source      factor
);

    import tdf_pkg::*;

    logic     full_reg, full_next;
    tdf_out_t data_reg, data_next;

    assign space = !full_reg || factor.ready;

    always_comb
    begin
        full_next = full_reg;
        data_next = data_reg;
        if (push && space)
        begin
            full_next = 1'b1;
            data_next = push_data;
        end
        else if (factor.ready)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign factor.valid   = full_reg;
    assign factor.payload = data_reg;

endmodule

>>> rtl/trial_division_factorizer.sv
// Top level of the trial division factorizer: sequencer around a bit-serial divider.
// Each trial division runs in the shared divider (load, one quotient bit per cycle,
// evaluate); an item needs about one division per trial divisor up to the square
// root of the value plus one per prime factor counted with multiplicity.
// Inputs 0 and 1 go straight to the closing beat without a division.
// One item is worked at a time; reset clears all control state and the full flag
// of the output register.
module trial_division_factorizer #(
    parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    tdf_stream_if.sink operand,
    tdf_stream_if.source factor
);

    import tdf_pkg::*;

    localparam int EW = $clog2(VALUE_WIDTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_REC   = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [EW-1:0]          e_reg, e_next;
    logic [VALUE_WIDTH-1:0] rec_prime_reg, rec_prime_next;
    logic [EW-1:0]          rec_exp_reg, rec_exp_next;
    logic                   rec_final_reg, rec_final_next;
    logic [VALUE_WIDTH-1:0] pend_prime_reg, pend_prime_next;
    logic [EW-1:0]          pend_exp_reg, pend_exp_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [NW-1:0]          cnt_reg, cnt_next;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    logic                   push;
    logic                   space;
    tdf_out_t               push_data;

    logic [VALUE_WIDTH+VALUE_IN_W-1:0] value_ext;
    logic [VALUE_WIDTH-1:0]            n_in;
    logic [VALUE_WIDTH+PRIME_W-1:0]    prime_ext;
    logic [EW+EXP_W-1:0]               exp_ext;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, operand.payload.value};
    assign n_in      = value_ext[VALUE_WIDTH-1:0];
    assign prime_ext = {{PRIME_W{1'b0}}, pend_prime_reg};
    assign exp_ext   = {{EXP_W{1'b0}}, pend_exp_reg};

    assign operand.ready = (state_reg == S_IDLE);
    assign div_start     = (state_reg == S_START);

    assign push = (state_reg == S_FINAL) || ((state_reg == S_REC) && pend_valid_reg);
    assign push_data.prime    = prime_ext[PRIME_W-1:0];
    assign push_data.exponent = exp_ext[EXP_W-1:0];
    assign push_data.last     = (state_reg == S_FINAL);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        e_next          = e_reg;
        rec_prime_next  = rec_prime_reg;
        rec_exp_next    = rec_exp_reg;
        rec_final_next  = rec_final_reg;
        pend_prime_next = pend_prime_reg;
        pend_exp_next   = pend_exp_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (operand.valid)
                begin
                    n_next          = n_in;
                    d_next          = VALUE_WIDTH'(2);
                    e_next          = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    if (n_in == '0)
                    begin
                        pend_prime_next = '0;
                        pend_exp_next   = '0;
                        pend_valid_next = 1'b1;
                        state_next      = S_FINAL;
                    end
                    else if (n_in == VALUE_WIDTH'(1))
                    begin
                        pend_prime_next = VALUE_WIDTH'(1);
                        pend_exp_next   = EW'(1);
                        pend_valid_next = 1'b1;
                        state_next      = S_FINAL;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // A fresh divisor must first pass the bound check d <= n / d;
                    // a divisor already dividing keeps going while the remainder is zero.
                    if ((e_reg == '0) && (d_reg > div_quo))
                    begin
                        if (n_reg != VALUE_WIDTH'(1))
                        begin
                            rec_prime_next = n_reg;
                            rec_exp_next   = EW'(1);
                            rec_final_next = 1'b1;
                            state_next     = S_REC;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    else if (div_rem == '0)
                    begin
                        n_next     = div_quo;
                        e_next     = e_reg + 1'b1;
                        state_next = S_START;
                    end
                    else
                    begin
                        d_next = d_reg + 1'b1;
                        e_next = '0;
                        if (e_reg != '0)
                        begin
                            rec_prime_next = d_reg;
                            rec_exp_next   = e_reg;
                            rec_final_next = 1'b0;
                            state_next     = S_REC;
                        end
                        else
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end
            S_REC:
            begin
                // The previous factor leaves only once a newer one proves it is not the last.
                if (!pend_valid_reg || space)
                begin
                    pend_prime_next = rec_prime_reg;
                    pend_exp_next   = rec_exp_reg;
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    if (rec_final_reg || (cnt_reg == NW'(MAX_RESULTS - 1)))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_FINAL:
            begin
                if (space)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            e_reg          <= '0;
            rec_final_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            e_reg          <= e_next;
            rec_final_reg  <= rec_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        d_reg          <= d_next;
        rec_prime_reg  <= rec_prime_next;
        rec_exp_reg    <= rec_exp_next;
        pend_prime_reg <= pend_prime_next;
        pend_exp_reg   <= pend_exp_next;
    end

    tdf_divider #(
        .W (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    tdf_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .factor    (factor)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(MAX_RESULTS))
        else $error("factor count exceeds the result limit");

    a_final_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |-> pend_valid_reg)
        else $error("closing beat without a pending factor");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (operand.valid && operand.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after taking an operand");

endmodule
